// ===== sv/cfcobs_pkg.sv =====
// Shared types and constants for the checksummed frame COBS encoder.
// Used by every module of the block; depends on nothing else.
package cfcobs_pkg;

  // Frame and encoding sizes.
  localparam int FRAME_LEN = 6;
  localparam int ENC_LEN   = 7;
  localparam int OUT_LEN   = ENC_LEN + 1;
  localparam int IDX_W     = $clog2(OUT_LEN);

  // Byte constants.
  localparam logic [7:0] START_RESET = 8'h0A;
  localparam logic [7:0] CSUM_BASE   = 8'hFF;
  localparam logic [7:0] DELIM       = 8'h00;

  // Position of the delimiter in the output sequence.
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(OUT_LEN - 1);

  typedef logic [7:0] byte_t;

  // One input item: four payload bytes.
  typedef struct packed {
    byte_t data0;
    byte_t data1;
    byte_t data2;
    byte_t data3;
  } in_item_t;

  // One result item: one encoded byte and the end-of-frame flag.
  typedef struct packed {
    byte_t out_byte;
    logic  last_byte;
  } out_item_t;

  // Raw frame: index 0 is the start byte, index 5 the checksum.
  typedef byte_t [FRAME_LEN-1:0] frame_t;

  // Frame with a virtual zero on each side, as seen by the encoder.
  typedef byte_t [OUT_LEN-1:0] ext_frame_t;

  // Full output sequence: seven encoded bytes and the delimiter.
  typedef byte_t [OUT_LEN-1:0] out_seq_t;

endpackage

// ===== sv/cfcobs_csum.sv =====
// Checksum pipeline: two register stages that build the six-byte frame.
// Depends on cfcobs_pkg.
module cfcobs_csum (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cfcobs_pkg::in_item_t in_data,
  input  cfcobs_pkg::byte_t    start_byte,
  output logic                 frm_valid,
  input  logic                 frm_ready,
  output cfcobs_pkg::frame_t   frm_data
);

  // Stage one registers: payload, start byte and two partial sums.
  logic                s1_v_r;
  cfcobs_pkg::byte_t   s1_start_r, s1_d0_r, s1_d1_r, s1_d2_r, s1_d3_r;
  cfcobs_pkg::byte_t   s1_sum_a_r, s1_sum_b_r;
  // Stage two registers: complete frame.
  logic                s2_v_r;
  cfcobs_pkg::frame_t  s2_frame_r;

  logic s1_ready, s2_ready;

  // Each stage moves when it is empty or its successor takes its item.
  assign s2_ready = !s2_v_r || frm_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ready = s1_ready;

  // Stage one valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= in_valid;
    end
  end

  // Stage one payload: first partial sums of the frame bytes.
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_start_r <= start_byte;
      s1_d0_r    <= in_data.data0;
      s1_d1_r    <= in_data.data1;
      s1_d2_r    <= in_data.data2;
      s1_d3_r    <= in_data.data3;
      s1_sum_a_r <= start_byte + in_data.data0;
      s1_sum_b_r <= in_data.data1 + in_data.data2;
    end
  end

  // Stage two valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_v_r;
    end
  end

  // Stage two payload: the checksum closes the frame.
  always_ff @(posedge clk) begin
    if (s2_ready && s1_v_r) begin
      s2_frame_r[0] <= s1_start_r;
      s2_frame_r[1] <= s1_d0_r;
      s2_frame_r[2] <= s1_d1_r;
      s2_frame_r[3] <= s1_d2_r;
      s2_frame_r[4] <= s1_d3_r;
      s2_frame_r[5] <= cfcobs_pkg::CSUM_BASE - (s1_sum_a_r + s1_sum_b_r + s1_d3_r);
    end
  end

  assign frm_valid = s2_v_r;
  assign frm_data  = s2_frame_r;

endmodule

// ===== sv/cfcobs_enc.sv =====
// COBS encoding pipeline: zero detection stage and code byte stage.
// Depends on cfcobs_pkg.
module cfcobs_enc (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 frm_valid,
  output logic                 frm_ready,
  input  cfcobs_pkg::frame_t   frm_data,
  output logic                 enc_valid,
  input  logic                 enc_ready,
  output cfcobs_pkg::out_seq_t enc_data
);

  // Stage three: frame padded with a virtual zero at each end, zero flags.
  logic                     s3_v_r;
  cfcobs_pkg::ext_frame_t   s3_ext_r;
  logic [cfcobs_pkg::OUT_LEN-1:0] s3_zero_r;
  // Stage four: encoded bytes followed by the delimiter.
  logic                     s4_v_r;
  cfcobs_pkg::out_seq_t     s4_seq_r;

  cfcobs_pkg::ext_frame_t   ext_nxt;
  logic [cfcobs_pkg::OUT_LEN-1:0] zero_nxt;
  cfcobs_pkg::out_seq_t     seq_nxt;

  logic s3_ready, s4_ready;

  assign s4_ready  = !s4_v_r || enc_ready;
  assign s3_ready  = !s3_v_r || s4_ready;
  assign frm_ready = s3_ready;

  // Pad the frame and flag every zero byte.
  always_comb begin
    ext_nxt[0]                      = cfcobs_pkg::DELIM;
    ext_nxt[cfcobs_pkg::OUT_LEN-1]  = cfcobs_pkg::DELIM;
    for (int k = 0; k < cfcobs_pkg::FRAME_LEN; k++) begin
      ext_nxt[k+1] = frm_data[k];
    end
    for (int k = 0; k < cfcobs_pkg::OUT_LEN; k++) begin
      zero_nxt[k] = (ext_nxt[k] == cfcobs_pkg::DELIM);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_ready) begin
      s3_v_r <= frm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && frm_valid) begin
      s3_ext_r  <= ext_nxt;
      s3_zero_r <= zero_nxt;
    end
  end

  // Each zero position becomes a code byte holding the distance to the
  // next zero; nonzero bytes pass through unchanged.
  always_comb begin
    logic [cfcobs_pkg::IDX_W-1:0] gap;
    gap = '0;
    for (int k = 0; k < cfcobs_pkg::ENC_LEN; k++) begin
      gap = '0;
      for (int j = cfcobs_pkg::OUT_LEN - 1; j > k; j--) begin
        if (s3_zero_r[j]) begin
          gap = cfcobs_pkg::IDX_W'(j - k);
        end
      end
      if (s3_zero_r[k]) begin
        seq_nxt[k] = {{(8 - cfcobs_pkg::IDX_W){1'b0}}, gap};
      end else begin
        seq_nxt[k] = s3_ext_r[k];
      end
    end
    seq_nxt[cfcobs_pkg::OUT_LEN-1] = cfcobs_pkg::DELIM;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (s4_ready) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready && s3_v_r) begin
      s4_seq_r <= seq_nxt;
    end
  end

  assign enc_valid = s4_v_r;
  assign enc_data  = s4_seq_r;

endmodule

// ===== sv/cfcobs_ser.sv =====
// Byte serializer: holds one encoded frame and sends it one item per cycle
// while out_ready is high. Depends on cfcobs_pkg.
module cfcobs_ser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  enc_valid,
  output logic                  enc_ready,
  input  cfcobs_pkg::out_seq_t  enc_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cfcobs_pkg::out_item_t out_data
);

  logic                           busy_r;
  logic [cfcobs_pkg::IDX_W-1:0]   idx_r;
  cfcobs_pkg::out_seq_t           buf_r;

  logic at_last, take, load;

  assign at_last   = (idx_r == cfcobs_pkg::LAST_IDX);
  assign take      = busy_r && out_ready;
  // A new frame loads as soon as the delimiter of the current one leaves.
  assign enc_ready = !busy_r || (out_ready && at_last);
  assign load      = enc_ready && enc_valid;

  // Control: busy flag and byte index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (take) begin
      if (at_last) begin
        busy_r <= 1'b0;
        idx_r  <= '0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // Frame buffer.
  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= enc_data;
    end
  end

  assign out_valid          = busy_r;
  assign out_data.out_byte  = buf_r[idx_r];
  assign out_data.last_byte = at_last;

endmodule

// ===== sv/checksummed_frame_cobs_encoder_unit.sv =====
// Top level of the checksummed frame COBS encoder.
// Depends on cfcobs_pkg, cfcobs_csum, cfcobs_enc and cfcobs_ser.
//
// Each input item carries four payload bytes. The block prefixes the
// configured start byte (0x0A after reset), appends a checksum of 0xFF
// minus the mod-256 sum of the first five bytes, COBS encodes the six-byte
// frame and sends eight result items: seven encoded bytes, then a 0x00
// delimiter with last_byte set. The byte-wide output serializer sets the
// throughput; it takes a new frame as the delimiter of the current one leaves.
// Four pipeline stages (partial sums, checksum, zero detection, code bytes)
// sit in front of the serializer, which registers each frame before its
// first byte is offered, and up to five items can be in flight.
// The start byte register is written through the cfg port, always ready.
module checksummed_frame_cobs_encoder_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cfcobs_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cfcobs_pkg::out_item_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_data
);

  cfcobs_pkg::byte_t    start_byte_r;
  logic                 frm_valid, frm_ready;
  cfcobs_pkg::frame_t   frm_data;
  logic                 enc_valid, enc_ready;
  cfcobs_pkg::out_seq_t enc_data;

  // Start byte register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= cfcobs_pkg::START_RESET;
    end else if (cfg_valid && cfg_ready) begin
      start_byte_r <= cfg_data;
    end
  end

  cfcobs_csum u_csum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .start_byte (start_byte_r),
    .frm_valid  (frm_valid),
    .frm_ready  (frm_ready),
    .frm_data   (frm_data)
  );

  cfcobs_enc u_enc (
    .clk       (clk),
    .rst_n     (rst_n),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready),
    .frm_data  (frm_data),
    .enc_valid (enc_valid),
    .enc_ready (enc_ready),
    .enc_data  (enc_data)
  );

  cfcobs_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .enc_valid (enc_valid),
    .enc_ready (enc_ready),
    .enc_data  (enc_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A frame, once started, continues without a gap until its delimiter.
  a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_byte |=> out_valid)
    else $error("output frame broken before its delimiter");

  // COBS output never carries a zero before the delimiter.
  a_no_inner_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_byte |-> out_data.out_byte != cfcobs_pkg::DELIM)
    else $error("zero byte inside an encoded frame");

  // After a delimiter leaves, the next item is the first byte of a frame.
  a_first_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_byte |=> !out_data.last_byte)
    else $error("delimiter repeated");

endmodule
